@@ hw/rtl/radial_speed_tracker_macros.svh @@
// Assertion macros for the radial speed tracker.
`ifndef RADIAL_SPEED_TRACKER_MACROS_SVH
`define RADIAL_SPEED_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define RSPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/rspd_pkg.sv @@
`timescale 1ns / 1ps
package rspd_pkg;
  localparam int POS_W   = 24;
  localparam int DIFF_W  = 25;
  localparam int SPEED_W = 24;
  localparam int SUM_W   = 56;
  localparam int SQ_W    = 50;
  localparam int ROOT_W  = 25;
  localparam int DEN_W   = 49;
  localparam int DOT_W   = 51;
  localparam int MAG_W   = 50;
  localparam int REM_W   = 28;
  localparam int MUL_W   = 26;
  localparam int PROD_W  = 52;
  localparam int QUOT_W  = 24;
  localparam int STEP_W  = 5;

  localparam logic [1:0] REG_RADAR_X  = 2'd0;
  localparam logic [1:0] REG_RADAR_Y  = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_ON_RADAR,
    KIND_MEASURE
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  lx;
    logic signed [DIFF_W-1:0]  ly;
  } work_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DX,
    ST_MUL_DY,
    ST_MUL_LX,
    ST_MUL_LY,
    ST_SUM_SQ,
    ST_SQRT,
    ST_MUL_DEN,
    ST_SPD_INIT,
    ST_SPD_DIV,
    ST_STATS,
    ST_MEAN_INIT,
    ST_MEAN_DIV,
    ST_DONE
  } back_state_t;
endpackage

@@ hw/rtl/radial_speed_tracker.sv @@
`timescale 1ns / 1ps
// Channel  | Ports                                  | Direction
// ---------+----------------------------------------+----------
// input    | in_valid, in_stall, in_vehicle_x/y      | in
// result   | out_valid, out_stall, out_* fields      | out
// config   | cfg_we, cfg_index, cfg_data             | in
//
// A measured word goes through 25 square root steps and two 24-step long divisions on
// one shared divider, plus the multiply sequence. A saturated speed or mean skips its
// division. First samples and on-radar words skip the arithmetic.
// Reset is synchronous, active low; no clearing pass is needed.
// A two-word queue lets the input side keep accepting while the back end
// computes or waits on out_stall.
`include "radial_speed_tracker_macros.svh"
module radial_speed_tracker #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rspd_pkg::POS_W-1:0]   in_vehicle_x,
  input  logic signed [rspd_pkg::POS_W-1:0]   in_vehicle_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_measured,
  output logic                                out_on_radar,
  output logic [rspd_pkg::SPEED_W-1:0]        out_radial_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_min_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_max_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_mean_speed,
  output logic [31:0]                         out_sample_count,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [rspd_pkg::POS_W-1:0]          cfg_data
);
  import rspd_pkg::*;

  logic signed [POS_W-1:0] radar_x_r, radar_y_r;
  logic [POS_W-1:0]        interval_r;
  queue_status_t           q_status;
  work_t                   push_word, pop_word;
  logic                    push, pop;
  logic                    speed_bounded;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radar_x_r  <= '0;
      radar_y_r  <= '0;
      interval_r <= 24'h100000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADAR_X:  radar_x_r  <= cfg_data;
        REG_RADAR_Y:  radar_y_r  <= cfg_data;
        REG_INTERVAL: interval_r <= cfg_data;
        default:      interval_r <= interval_r;
      endcase
    end
  end

  rspd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_vehicle_x (in_vehicle_x),
    .in_vehicle_y (in_vehicle_y),
    .radar_x      (radar_x_r),
    .radar_y      (radar_y_r),
    .q_status     (q_status),
    .push         (push),
    .push_word    (push_word)
  );

  rspd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .status    (q_status)
  );

  rspd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .q_word           (pop_word),
    .q_pop            (pop),
    .sample_interval  (interval_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_measured     (out_measured),
    .out_on_radar     (out_on_radar),
    .out_radial_speed (out_radial_speed),
    .out_min_speed    (out_min_speed),
    .out_max_speed    (out_max_speed),
    .out_mean_speed   (out_mean_speed),
    .out_sample_count (out_sample_count)
  );

  assign speed_bounded = (out_min_speed <= out_radial_speed) &&
                         (out_max_speed >= out_radial_speed);

  `RSPD_ASSERT_IMPLY(a_flags_excl, clk, rst_n, out_valid && out_measured, !out_on_radar)
  `RSPD_ASSERT_IMPLY(a_speed_in_range, clk, rst_n, out_valid && out_measured, speed_bounded)
  `RSPD_ASSERT_IMPLY(a_mean_le_max, clk, rst_n, out_valid, out_mean_speed <= out_max_speed)
endmodule

@@ hw/rtl/rspd_front.sv @@
`timescale 1ns / 1ps
module rspd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rspd_pkg::POS_W-1:0]  in_vehicle_x,
  input  logic signed [rspd_pkg::POS_W-1:0]  in_vehicle_y,
  input  logic signed [rspd_pkg::POS_W-1:0]  radar_x,
  input  logic signed [rspd_pkg::POS_W-1:0]  radar_y,
  input  rspd_pkg::queue_status_t            q_status,
  output logic                               push,
  output rspd_pkg::work_t                    push_word
);
  import rspd_pkg::*;

  logic signed [POS_W-1:0] last_x_r, last_y_r;
  logic                    have_last_r;
  logic signed [DIFF_W-1:0] lx, ly;

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  assign lx = DIFF_W'(in_vehicle_x) - DIFF_W'(radar_x);
  assign ly = DIFF_W'(in_vehicle_y) - DIFF_W'(radar_y);

  always_comb begin
    push_word.dx = DIFF_W'(in_vehicle_x) - DIFF_W'(last_x_r);
    push_word.dy = DIFF_W'(in_vehicle_y) - DIFF_W'(last_y_r);
    push_word.lx = lx;
    push_word.ly = ly;
    if (!have_last_r) begin
      push_word.kind = KIND_FIRST;
    end else if (lx == '0 && ly == '0) begin
      push_word.kind = KIND_ON_RADAR;
    end else begin
      push_word.kind = KIND_MEASURE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      have_last_r <= 1'b0;
    end else if (push) begin
      last_x_r    <= in_vehicle_x;
      last_y_r    <= in_vehicle_y;
      have_last_r <= 1'b1;
    end
  end
endmodule

@@ hw/rtl/rspd_queue.sv @@
`timescale 1ns / 1ps
module rspd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rspd_pkg::work_t         push_word,
  input  logic                    pop,
  output rspd_pkg::work_t         pop_word,
  output rspd_pkg::queue_status_t status
);
  import rspd_pkg::*;

  work_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;

  assign status.full     = (fill_r == 2'd2);
  assign status.nonempty = (fill_r != 2'd0);
  assign pop_word        = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end
endmodule

@@ hw/rtl/rspd_back.sv @@
`timescale 1ns / 1ps
module rspd_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rspd_pkg::queue_status_t             q_status,
  input  rspd_pkg::work_t                     q_word,
  output logic                                q_pop,
  input  logic [rspd_pkg::POS_W-1:0]          sample_interval,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_measured,
  output logic                                out_on_radar,
  output logic [rspd_pkg::SPEED_W-1:0]        out_radial_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_min_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_max_speed,
  output logic [rspd_pkg::SPEED_W-1:0]        out_mean_speed,
  output logic [31:0]                         out_sample_count
);
  import rspd_pkg::*;

  localparam int DVW = (COUNT_BITS > DEN_W) ? COUNT_BITS : DEN_W;
  localparam int RW  = DVW + 1;
  localparam int MW  = (COUNT_BITS + QUOT_W > SUM_W) ? COUNT_BITS + QUOT_W : SUM_W;

  back_state_t state_r, state_nxt;

  work_t                     work_r;
  logic                      meas_r, onr_r;
  logic signed [PROD_W-1:0]  prod_r, acc_r;
  logic signed [DOT_W-1:0]   dot_r;
  logic [SQ_W-1:0]           sq_r;
  logic [ROOT_W-1:0]         root_r;
  logic [REM_W-1:0]          rem_r;
  logic [STEP_W-1:0]         step_r;
  logic [DVW-1:0]            dvs_r;
  logic [RW-1:0]             div_r;
  logic [QUOT_W-1:0]         nb_r, q_r;
  logic [SPEED_W-1:0]        speed_r, low_r, high_r, mean_r;
  logic [SUM_W-1:0]          sum_r;
  logic [COUNT_BITS-1:0]     count_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [REM_W-1:0]          rem_sh, trial;
  logic                      sq_ge;
  logic [RW-1:0]             div_sh;
  logic                      div_ge;
  logic [QUOT_W-1:0]         q_nxt;
  logic signed [DOT_W-1:0]   dot_abs;
  logic [MAG_W-1:0]          mag;
  logic [DEN_W-1:0]          den;
  logic                      spd_sat, mean_sat, last_step, out_load;
  logic [SUM_W:0]            sum_ext;
  logic [63:0]               count_ext;

  // shared multiplier
  always_comb begin
    case (state_r)
      ST_MUL_DX:  begin mul_a = MUL_W'(work_r.dx); mul_b = MUL_W'(work_r.lx); end
      ST_MUL_DY:  begin mul_a = MUL_W'(work_r.dy); mul_b = MUL_W'(work_r.ly); end
      ST_MUL_LX:  begin mul_a = MUL_W'(work_r.lx); mul_b = MUL_W'(work_r.lx); end
      ST_MUL_LY:  begin mul_a = MUL_W'(work_r.ly); mul_b = MUL_W'(work_r.ly); end
      ST_MUL_DEN: begin
        mul_a = $signed({2'b00, sample_interval});
        mul_b = $signed({1'b0, root_r});
      end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // square root step
  assign rem_sh = {rem_r[REM_W-3:0], sq_r[SQ_W-1:SQ_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign sq_ge  = (rem_sh >= trial);

  // shared long division step
  assign div_sh = {div_r[RW-2:0], nb_r[QUOT_W-1]};
  assign div_ge = (div_sh >= RW'(dvs_r));
  assign q_nxt  = {q_r[QUOT_W-2:0], div_ge};

  assign dot_abs  = dot_r[DOT_W-1] ? -dot_r : dot_r;
  assign mag      = dot_abs[MAG_W-1:0];
  assign den      = prod_r[DEN_W-1:0];
  assign spd_sat  = (den == '0) || ((DEN_W + 4)'(mag) >= {den, 4'b0000});
  assign mean_sat = (MW'(sum_r) >= MW'({count_r, {QUOT_W{1'b0}}}));
  assign sum_ext  = {1'b0, sum_r} + (SUM_W + 1)'(q_r);
  assign count_ext = 64'(count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_status.nonempty) begin
          state_nxt = (q_word.kind == KIND_MEASURE) ? ST_MUL_DX : ST_DONE;
        end
      end
      ST_MUL_DX:    state_nxt = ST_MUL_DY;
      ST_MUL_DY:    state_nxt = ST_MUL_LX;
      ST_MUL_LX:    state_nxt = ST_MUL_LY;
      ST_MUL_LY:    state_nxt = ST_SUM_SQ;
      ST_SUM_SQ:    state_nxt = ST_SQRT;
      ST_SQRT:      state_nxt = last_step ? ST_MUL_DEN : ST_SQRT;
      ST_MUL_DEN:   state_nxt = ST_SPD_INIT;
      ST_SPD_INIT:  state_nxt = spd_sat ? ST_STATS : ST_SPD_DIV;
      ST_SPD_DIV:   state_nxt = last_step ? ST_STATS : ST_SPD_DIV;
      ST_STATS:     state_nxt = ST_MEAN_INIT;
      ST_MEAN_INIT: state_nxt = mean_sat ? ST_DONE : ST_MEAN_DIV;
      ST_MEAN_DIV:  state_nxt = last_step ? ST_DONE : ST_MEAN_DIV;
      ST_DONE:      state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    out_load  = 1'b0;
    last_step = 1'b0;
    case (state_r)
      ST_IDLE:     q_pop = q_status.nonempty;
      ST_SQRT:     last_step = (step_r == STEP_W'(ROOT_W - 1));
      ST_SPD_DIV,
      ST_MEAN_DIV: last_step = (step_r == STEP_W'(QUOT_W - 1));
      ST_DONE:     out_load = !out_valid || !out_stall;
      default:     q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      low_r     <= '1;
      high_r    <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      mean_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_STATS: begin
          if (q_r < low_r) begin
            low_r <= q_r;
          end
          if (q_r > high_r) begin
            high_r <= q_r;
          end
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
            sum_r   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          end
        end
        ST_MEAN_INIT: begin
          if (mean_sat) begin
            mean_r <= '1;
          end
        end
        ST_MEAN_DIV: begin
          if (last_step) begin
            mean_r <= q_nxt;
          end
        end
        default: mean_r <= mean_r;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        work_r  <= q_word;
        meas_r  <= (q_word.kind == KIND_MEASURE);
        onr_r   <= (q_word.kind == KIND_ON_RADAR);
        speed_r <= '0;
      end
      ST_MUL_DX: prod_r <= mul_p;
      ST_MUL_DY: begin
        prod_r <= mul_p;
        acc_r  <= prod_r;
      end
      ST_MUL_LX: begin
        prod_r <= mul_p;
        dot_r  <= DOT_W'(acc_r) + DOT_W'(prod_r);
      end
      ST_MUL_LY: begin
        prod_r <= mul_p;
        acc_r  <= prod_r;
      end
      ST_SUM_SQ: begin
        sq_r   <= SQ_W'(acc_r + prod_r);
        root_r <= '0;
        rem_r  <= '0;
        step_r <= '0;
      end
      ST_SQRT: begin
        rem_r  <= sq_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
        sq_r   <= {sq_r[SQ_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
      end
      ST_MUL_DEN: prod_r <= mul_p;
      ST_SPD_INIT: begin
        q_r    <= spd_sat ? '1 : '0;
        dvs_r  <= DVW'(den);
        div_r  <= RW'(mag[MAG_W-1:4]);
        nb_r   <= {mag[3:0], {(QUOT_W - 4){1'b0}}};
        step_r <= '0;
      end
      ST_SPD_DIV,
      ST_MEAN_DIV: begin
        div_r  <= div_ge ? div_sh - RW'(dvs_r) : div_sh;
        nb_r   <= {nb_r[QUOT_W-2:0], 1'b0};
        q_r    <= q_nxt;
        step_r <= step_r + 1'b1;
      end
      ST_STATS: speed_r <= q_r;
      ST_MEAN_INIT: begin
        q_r    <= '0;
        dvs_r  <= DVW'(count_r);
        div_r  <= RW'(sum_r[SUM_W-1:QUOT_W]);
        nb_r   <= sum_r[QUOT_W-1:0];
        step_r <= '0;
      end
      ST_DONE: begin
        if (out_load) begin
          out_measured     <= meas_r;
          out_on_radar     <= onr_r;
          out_radial_speed <= speed_r;
          out_min_speed    <= low_r;
          out_max_speed    <= high_r;
          out_mean_speed   <= mean_r;
          out_sample_count <= (|count_ext[63:32]) ? '1 : count_ext[31:0];
        end
      end
      default: step_r <= step_r;
    endcase
  end
endmodule
